// ===== hdl/lru_row_slot_cache_assert.svh =====
// Assertion macros for the checker file of the row slot cache.
`ifndef LRU_ROW_SLOT_CACHE_ASSERT_SVH
`define LRU_ROW_SLOT_CACHE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, quiet while aresetn is low.
`define LRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, quiet while aresetn is low.
`define LRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lrc_pkg.sv =====
// Shared constants and types of the row slot cache.
package lrc_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int NUM_ROWS  = 1024;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int ROW_W  = $clog2(NUM_ROWS);
    localparam int FILL_W = $clog2(NUM_SLOTS + 1);
    localparam int DIR_W  = SLOT_W + 1;
    localparam int CAP_W  = 7;
    localparam int LIM_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_LIMIT = 2'd1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET    = 7'd64;
    localparam logic [LIM_W-1:0] INDEX_LIMIT_RESET = 11'd1024;

    // Token handed from cell to cell along the recency chain.
    typedef struct packed {
        logic              shift;   // still looking for the target slot
        logic              fin;     // update finished, marker runs to the tail
        logic              upd;     // least recent slot changes to data
        logic [SLOT_W-1:0] target;
        logic [SLOT_W-1:0] data;
    } lrc_token_t;

endpackage

// ===== hdl/lrc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/lrc_cell.sv =====
// One position of the recency chain: holds one slot number and passes the update token on.
module lrc_cell
    import lrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  lrc_token_t tok_in,
    input  logic       next_valid,
    output lrc_token_t tok_out,
    output logic       valid
);

    logic [SLOT_W-1:0] content_reg, content_next;
    logic              valid_reg, valid_next;
    lrc_token_t        tok_reg, tok_next;

    always_comb begin
        content_next = content_reg;
        valid_next   = valid_reg;
        tok_next     = '0;
        if (tok_in.shift) begin
            content_next = tok_in.data;
            if (!valid_reg) begin
                // empty position: absorb the shifted entry, tail unchanged
                valid_next   = 1'b1;
                tok_next.fin = 1'b1;
            end else if (content_reg == tok_in.target) begin
                // found the moved slot: absorb, report a new tail if here
                tok_next.fin  = 1'b1;
                tok_next.upd  = !next_valid;
                tok_next.data = tok_in.data;
            end else begin
                tok_next.shift  = 1'b1;
                tok_next.target = tok_in.target;
                tok_next.data   = content_reg;
            end
        end else if (tok_in.fin) begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        content_reg <= content_next;
    end

    assign tok_out = tok_reg;
    assign valid   = valid_reg;

endmodule

// ===== hdl/lru_row_slot_cache.sv =====
// Top level of the row slot cache directory: sequencer, directory memories and recency chain.
//
//   channel | direction | handshake            | payload
//   s_      | in        | s_valid / s_ready    | s_row_index
//   m_      | out       | m_valid / m_ready    | m_hit, m_slot, m_uncached, m_evicted_valid,
//           |           |                      | m_evicted_index, m_index_error
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An index error or a zero capacity goes from accept straight to the finish state. Any other
// request passes the lookup state, on a full miss the eviction states, then the wave state:
// the recency update is a token that walks the chain of NUM_SLOTS cells one cell a cycle
// and must reach the tail. After reset a clearing pass over all NUM_ROWS rows (1024) empties
// the row directory; s_ready stays low meanwhile, configuration beats are taken at any time.
// A finished result waits in the output register; the next beat is accepted meanwhile,
// and a second result holds in the sequencer until the output register frees.
module lru_row_slot_cache
    import lrc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ROW_W-1:0]      s_row_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [SLOT_W-1:0]     m_slot,
    output logic                  m_uncached,
    output logic                  m_evicted_valid,
    output logic [ROW_W-1:0]      m_evicted_index,
    output logic                  m_index_error,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_LOOKUP  = 7'b0000100,
        ST_EVREAD  = 7'b0001000,
        ST_EVWRITE = 7'b0010000,
        ST_WAVE    = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CAP_W-1:0] capacity_reg;
    logic [LIM_W-1:0] index_limit_reg;

    // control state
    logic [ROW_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SLOT_W-1:0] least_reg, least_next;
    logic              wave_done_reg, wave_done_next;
    logic              m_valid_reg, m_valid_next;

    // request and result being worked on
    logic [ROW_W-1:0]  idx_reg, idx_next;
    logic              res_hit_reg, res_hit_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_unc_reg, res_unc_next;
    logic              res_ev_reg, res_ev_next;
    logic [ROW_W-1:0]  res_evidx_reg, res_evidx_next;
    logic              res_err_reg, res_err_next;

    // output register
    logic              out_load;
    logic              m_hit_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic              m_unc_reg;
    logic              m_ev_reg;
    logic [ROW_W-1:0]  m_evidx_reg;
    logic              m_err_reg;

    // memories
    logic              dir_we;
    logic [ROW_W-1:0]  dir_waddr;
    logic [DIR_W-1:0]  dir_wdata;
    logic [DIR_W-1:0]  dir_rdata;
    logic              row_we;
    logic [SLOT_W-1:0] row_waddr;
    logic [ROW_W-1:0]  row_wdata;
    logic [ROW_W-1:0]  row_rdata;

    // chain
    logic              inject;
    logic [SLOT_W-1:0] inj_slot;
    lrc_token_t        inj_tok;
    lrc_token_t        tok_chain [NUM_SLOTS+1];
    logic              cell_valid [NUM_SLOTS];
    lrc_token_t        tail_tok;

    logic [FILL_W-1:0] cap_eff;
    logic [LIM_W-1:0]  lim_eff;
    logic              in_err;

    // Clamp oversized registers to the real sizes.
    assign cap_eff = (int'(capacity_reg) > NUM_SLOTS) ? FILL_W'(NUM_SLOTS)
                                                      : FILL_W'(capacity_reg);
    assign lim_eff = (int'(index_limit_reg) > NUM_ROWS) ? LIM_W'(NUM_ROWS) : index_limit_reg;
    assign in_err  = LIM_W'(s_row_index) >= lim_eff;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration beats: unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg    <= CAPACITY_RESET;
            index_limit_reg <= INDEX_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CAPACITY:    capacity_reg    <= cfg_data[CAP_W-1:0];
                CFG_INDEX_LIMIT: index_limit_reg <= cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Row directory: one entry per row, valid bit over slot number.
    lrc_ram #(
        .WIDTH (DIR_W),
        .DEPTH (NUM_ROWS)
    ) u_dir (
        .aclk  (aclk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .raddr (s_row_index),
        .rdata (dir_rdata)
    );

    // Slot to row table, read only at the least recent slot for evictions.
    lrc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SLOTS)
    ) u_rows (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (least_reg),
        .rdata (row_rdata)
    );

    // Recency chain: cell 0 is the most recent slot, the last valid cell the least recent.
    always_comb begin
        inj_tok        = '0;
        inj_tok.shift  = inject;
        inj_tok.target = inj_slot;
        inj_tok.data   = inj_slot;
    end

    assign tok_chain[0] = inj_tok;

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        logic nxt_valid;
        if (k == NUM_SLOTS - 1) begin : g_tail
            assign nxt_valid = 1'b0;
        end else begin : g_mid
            assign nxt_valid = cell_valid[k+1];
        end
        lrc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .tok_in     (tok_chain[k]),
            .next_valid (nxt_valid),
            .tok_out    (tok_chain[k+1]),
            .valid      (cell_valid[k])
        );
    end

    assign tail_tok = tok_chain[NUM_SLOTS];

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        fill_next      = fill_reg;
        least_next     = least_reg;
        idx_next       = idx_reg;
        res_hit_next   = res_hit_reg;
        res_slot_next  = res_slot_reg;
        res_unc_next   = res_unc_reg;
        res_ev_next    = res_ev_reg;
        res_evidx_next = res_evidx_reg;
        res_err_next   = res_err_reg;
        dir_we         = 1'b0;
        dir_waddr      = idx_reg;
        dir_wdata      = '0;
        row_we         = 1'b0;
        row_waddr      = res_slot_reg;
        row_wdata      = idx_reg;
        inject         = 1'b0;
        inj_slot       = res_slot_reg;
        out_load       = 1'b0;

        // take the new tail when the update token leaves the chain
        if (tail_tok.fin && tail_tok.upd) begin
            least_next = tail_tok.data;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                dir_we       = 1'b1;
                dir_waddr    = clr_cnt_reg;
                dir_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ROW_W'(NUM_ROWS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    idx_next       = s_row_index;
                    res_hit_next   = 1'b0;
                    res_slot_next  = '0;
                    res_unc_next   = 1'b0;
                    res_ev_next    = 1'b0;
                    res_evidx_next = '0;
                    res_err_next   = 1'b0;
                    if (in_err) begin
                        res_err_next = 1'b1;
                        state_next   = ST_FINISH;
                    end else if (cap_eff == '0) begin
                        res_unc_next = 1'b1;
                        state_next   = ST_FINISH;
                    end else begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: begin
                inject = 1'b1;
                if (dir_rdata[SLOT_W]) begin
                    // hit: move the slot to the front
                    res_hit_next  = 1'b1;
                    res_slot_next = dir_rdata[SLOT_W-1:0];
                    inj_slot      = dir_rdata[SLOT_W-1:0];
                    state_next    = ST_WAVE;
                end else if (fill_reg < cap_eff) begin
                    // miss with a free slot: fill in order
                    res_slot_next = fill_reg[SLOT_W-1:0];
                    inj_slot      = fill_reg[SLOT_W-1:0];
                    fill_next     = fill_reg + 1'b1;
                    dir_we        = 1'b1;
                    dir_waddr     = idx_reg;
                    dir_wdata     = {1'b1, fill_reg[SLOT_W-1:0]};
                    row_we        = 1'b1;
                    row_waddr     = fill_reg[SLOT_W-1:0];
                    row_wdata     = idx_reg;
                    state_next    = ST_WAVE;
                end else begin
                    // miss when full: reuse the least recent slot
                    res_slot_next = least_reg;
                    inj_slot      = least_reg;
                    res_ev_next   = 1'b1;
                    state_next    = ST_EVREAD;
                end
            end
            ST_EVREAD: begin
                res_evidx_next = row_rdata;
                dir_we         = 1'b1;
                dir_waddr      = row_rdata;
                dir_wdata      = '0;
                state_next     = ST_EVWRITE;
            end
            ST_EVWRITE: begin
                dir_we     = 1'b1;
                dir_waddr  = idx_reg;
                dir_wdata  = {1'b1, res_slot_reg};
                row_we     = 1'b1;
                row_waddr  = res_slot_reg;
                row_wdata  = idx_reg;
                state_next = ST_WAVE;
            end
            ST_WAVE: begin
                if (wave_done_reg || tail_tok.fin) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign wave_done_next = inject ? 1'b0 : (wave_done_reg || tail_tok.fin);
    assign m_valid_next   = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            fill_reg      <= '0;
            least_reg     <= '0;
            wave_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            fill_reg      <= fill_next;
            least_reg     <= least_next;
            wave_done_reg <= wave_done_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        res_hit_reg   <= res_hit_next;
        res_slot_reg  <= res_slot_next;
        res_unc_reg   <= res_unc_next;
        res_ev_reg    <= res_ev_next;
        res_evidx_reg <= res_evidx_next;
        res_err_reg   <= res_err_next;
        if (out_load) begin
            m_hit_reg   <= res_hit_reg;
            m_slot_reg  <= res_slot_reg;
            m_unc_reg   <= res_unc_reg;
            m_ev_reg    <= res_ev_reg;
            m_evidx_reg <= res_evidx_reg;
            m_err_reg   <= res_err_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_slot          = m_slot_reg;
    assign m_uncached      = m_unc_reg;
    assign m_evicted_valid = m_ev_reg;
    assign m_evicted_index = m_evidx_reg;
    assign m_index_error   = m_err_reg;

endmodule

// ===== hdl/lrc_checker.sv =====
// Port-level checker of the row slot cache and its bind to the top level.
`include "lru_row_slot_cache_assert.svh"

module lrc_checker
    import lrc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_hit,
    input logic [SLOT_W-1:0]     m_slot,
    input logic                  m_uncached,
    input logic                  m_evicted_valid,
    input logic [ROW_W-1:0]      m_evicted_index,
    input logic                  m_index_error
);

    // hold a stalled result beat
    `LRC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_slot) && $stable(m_hit) && $stable(m_evicted_index), "result beat changed while stalled")

    // an index error carries no other flag
    `LRC_ASSERT_NOW(a_err_alone, m_valid && m_index_error, !m_hit && !m_uncached && !m_evicted_valid && m_slot == '0, "index error with other fields set")

    // an uncached beat gives no slot and no eviction
    `LRC_ASSERT_NOW(a_unc_clean, m_valid && m_uncached, !m_hit && !m_evicted_valid && m_slot == '0 && m_evicted_index == '0, "uncached beat with slot or eviction")

    // a hit never evicts, and no eviction reports row zero
    `LRC_ASSERT_NOW(a_ev_clean, m_valid && (m_hit || !m_evicted_valid), !m_evicted_valid && m_evicted_index == '0, "eviction fields wrong")

endmodule

bind lru_row_slot_cache lrc_checker u_lrc_checker (.*);
